// File: src/sgms_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling grid map store package
// Item types, mode and register codes, controller states and the shared
// saturation helper for the toroidal cell map.
// ----------------------------------------------------------------------------
package sgms_pkg;

	localparam int GRID_ROWS_DEF = 256;
	localparam int GRID_COLS_DEF = 256;
	localparam int CELL_BITS_DEF = 16;

	localparam logic [31:0] CELL_SIZE_RST = 32'd9830;

	localparam logic [2:0] MODE_READ     = 3'd0;
	localparam logic [2:0] MODE_WRITE    = 3'd1;
	localparam logic [2:0] MODE_RECENTER = 3'd2;
	localparam logic [2:0] MODE_CLEAR    = 3'd3;
	localparam logic [2:0] MODE_TO_CELL  = 3'd4;
	localparam logic [2:0] MODE_CENTER   = 3'd5;

	localparam logic [1:0] CFG_CELL_SIZE    = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_CELL = 2'd1;

	localparam logic signed [35:0] S32_MAX = 36'sh0_7FFF_FFFF;
	localparam logic signed [35:0] S32_MIN = -36'sh0_8000_0000;

	typedef struct packed {
		logic        [2:0]  mode;
		logic signed [15:0] row;
		logic signed [15:0] col;
		logic        [15:0] write_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} in_item_t;

	typedef struct packed {
		logic        [15:0] cell_value;
		logic               valid_res;
		logic               moved;
		logic signed [31:0] out_row;
		logic signed [31:0] out_col;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_CALC,
		ST_DECIDE,
		ST_ROWS,
		ST_COLS,
		ST_FILL,
		ST_MUL1,
		ST_MUL2,
		ST_EMIT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > S32_MAX) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < S32_MIN) begin
			return -32'sh7FFF_FFFF - 32'sd1;
		end
		return v[31:0];
	endfunction

endpackage

// File: src/scrolling_grid_map_store_top.sv
// ----------------------------------------------------------------------------
// Scrolling grid map store
// Robot-centered cell map in a circular store with scrolling recenter,
// whole-map clear and position to cell conversions.
// ----------------------------------------------------------------------------
// The input channel (in_data, in_valid, in_stall) takes one item at a time;
// every item gives exactly one result item on the output channel (out_data,
// out_valid, out_stall). The user must write registers through cfg_valid,
// cfg_ready, cfg_index and cfg_data only while the block is idle; the block
// itself does not enforce this. cfg_ready is always high. The controller and
// the cell memory set the work per item: write and unused modes go straight
// to the result, read waits for the registered memory data, cell center runs
// the states ST_MUL1 and ST_MUL2, point to cell runs two 32-step restoring
// divisions, and recenter runs the same divisions, then keeps the corner,
// rewrites the whole grid for a jump of a full grid or more, or clears
// GRID_COLS cells per scrolled row and GRID_ROWS per scrolled column.
// Clear rewrites every cell. After reset the memory is swept to zero, one
// cell a cycle, over all GRID_ROWS*GRID_COLS cells (65536 by default) before the first item is
// taken. The output register frees the input side: a new item is accepted
// while a finished result waits under out_stall, and a later result waits in
// its final state until the output register is free.
// ----------------------------------------------------------------------------
module scrolling_grid_map_store_top #(
	parameter int GRID_ROWS = sgms_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = sgms_pkg::GRID_COLS_DEF,
	parameter int CELL_BITS = sgms_pkg::CELL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sgms_pkg::in_item_t   in_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	output sgms_pkg::out_item_t  out_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import sgms_pkg::*;

	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int NCELL = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(NCELL);
	localparam int SW    = (RW > CW) ? RW : CW;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(GRID_COLS) + AW'(c);
	endfunction

	function automatic logic [RW-1:0] wrap_r(input logic [RW-1:0] a, input logic [RW-1:0] b);
		logic [RW:0] s;
		s = (RW+1)'(a) + (RW+1)'(b);
		if (s >= (RW+1)'(GRID_ROWS)) begin
			s = s - (RW+1)'(GRID_ROWS);
		end
		return s[RW-1:0];
	endfunction

	function automatic logic [CW-1:0] wrap_c(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(GRID_COLS)) begin
			s = s - (CW+1)'(GRID_COLS);
		end
		return s[CW-1:0];
	endfunction

	function automatic logic [RW-1:0] inc_r(input logic [RW-1:0] a);
		return (a == RW'(GRID_ROWS - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [RW-1:0] dec_r(input logic [RW-1:0] a);
		return (a == '0) ? RW'(GRID_ROWS - 1) : a - 1'b1;
	endfunction

	function automatic logic [CW-1:0] inc_c(input logic [CW-1:0] a);
		return (a == CW'(GRID_COLS - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [CW-1:0] dec_c(input logic [CW-1:0] a);
		return (a == '0) ? CW'(GRID_COLS - 1) : a - 1'b1;
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [31:0] half_sat(input logic [65:0] p, input logic neg);
		logic [65:0] h;
		h = {1'b0, p[65:1]} + (neg ? 66'(p[0]) : 66'd0);
		if (!neg) begin
			return (h > 66'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : h[31:0];
		end
		return (h > 66'h0_8000_0000) ? 32'h8000_0000 : (~h[31:0] + 32'd1);
	endfunction

	state_t state_q, state_d;
	in_item_t item_q;
	out_item_t res_q, out_q, res_init;
	logic out_valid_q;
	logic [31:0] cell_size_q, den;
	logic [15:0] default_q;
	logic signed [31:0] corner_row_q, corner_col_q, nr_q, nc_q;
	logic [RW-1:0] row_org_q, rcnt_q;
	logic [CW-1:0] col_org_q, ccnt_q;
	logic rdir_q, cdir_q;
	logic [SW-1:0] sweep_q;
	logic [AW-1:0] lin_q;
	logic [31:0] rem_q, quo_q, rem_n, quo_n;
	logic [32:0] rem_sh;
	logic div_ge, dneg_q, dsel_q;
	logic [4:0] cnt_q;
	logic signed [33:0] qy_q, qx_q, q_fin, nx_q, ny_q, dr, dc;
	logic [33:0] magx, magy, absdr, absdc, qmag;
	logic [63:0] plo_x_q, plo_y_q;
	logic [33:0] phi_x_q, phi_y_q;
	logic [65:0] px_sum, py_sum;
	logic signed [31:0] orow_c, ocol_c;
	logic acc, in_ok, out_free, dzero, dbig;
	logic [RW-1:0] in_pr, rtgt;
	logic [CW-1:0] in_pc, ctgt;
	logic sweep_end_r, sweep_end_c;

	logic [CELL_BITS-1:0] mem [NCELL];
	logic [CELL_BITS-1:0] rdata_q, wdata;
	logic [AW-1:0] waddr, raddr;
	logic we;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_data  = out_q;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign acc       = in_valid && (state_q == ST_IDLE);
	assign den       = (cell_size_q == '0) ? 32'd1 : cell_size_q;

	assign in_ok = !in_data.row[15] && ({1'b0, in_data.row[14:0]} < 16'(GRID_ROWS)) &&
		!in_data.col[15] && ({1'b0, in_data.col[14:0]} < 16'(GRID_COLS));
	assign in_pr = wrap_r(in_data.row[RW-1:0], row_org_q);
	assign in_pc = wrap_c(in_data.col[CW-1:0], col_org_q);
	assign rtgt  = rdir_q ? dec_r(row_org_q) : row_org_q;
	assign ctgt  = cdir_q ? dec_c(col_org_q) : col_org_q;
	assign sweep_end_r = (sweep_q == SW'(GRID_COLS - 1));
	assign sweep_end_c = (sweep_q == SW'(GRID_ROWS - 1));

	assign rem_sh = {rem_q, quo_q[31]};
	assign div_ge = (rem_sh >= {1'b0, den});
	assign rem_n  = div_ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
	assign quo_n  = {quo_q[30:0], div_ge};
	assign qmag   = {2'b00, quo_n};
	assign q_fin  = !dneg_q ? qmag : ((rem_n != '0) ? -(qmag + 34'd1) : -qmag);

	assign orow_c = sat32(36'(qy_q) - 36'(corner_row_q));
	assign ocol_c = sat32(36'(qx_q) - 36'(corner_col_q));

	assign dr    = 34'(nr_q) - 34'(corner_row_q);
	assign dc    = 34'(nc_q) - 34'(corner_col_q);
	assign absdr = dr[33] ? -dr : dr;
	assign absdc = dc[33] ? -dc : dc;
	assign dzero = (dr == '0) && (dc == '0);
	assign dbig  = (absdr >= 34'(GRID_ROWS)) || (absdc >= 34'(GRID_COLS));

	assign magx   = nx_q[33] ? -nx_q : nx_q;
	assign magy   = ny_q[33] ? -ny_q : ny_q;
	assign px_sum = 66'(plo_x_q) + {phi_x_q, 32'd0};
	assign py_sum = 66'(plo_y_q) + {phi_y_q, 32'd0};

	always_comb begin
		res_init = '0;
		res_init.valid_res = (in_data.mode == MODE_READ || in_data.mode == MODE_WRITE ||
			in_data.mode == MODE_CENTER) && in_ok;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (lin_q == AW'(NCELL - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.mode)
						MODE_READ: state_d = ST_READ;
						MODE_RECENTER, MODE_TO_CELL: state_d = ST_DIV;
						MODE_CLEAR: state_d = ST_FILL;
						MODE_CENTER: state_d = ST_MUL1;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_READ: state_d = ST_EMIT;
			ST_DIV: begin
				if (cnt_q == 5'd31 && dsel_q) state_d = ST_CALC;
			end
			ST_CALC: state_d = (item_q.mode == MODE_RECENTER) ? ST_DECIDE : ST_EMIT;
			ST_DECIDE: begin
				if (dzero) state_d = ST_EMIT;
				else if (dbig) state_d = ST_FILL;
				else state_d = ST_ROWS;
			end
			ST_ROWS: begin
				if (rcnt_q == '0) state_d = ST_COLS;
			end
			ST_COLS: begin
				if (ccnt_q == '0) state_d = ST_EMIT;
			end
			ST_FILL: begin
				if (lin_q == AW'(NCELL - 1)) state_d = ST_EMIT;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = lin_q;
		wdata = CELL_BITS'(default_q);
		raddr = cell_addr(in_pr, in_pc);
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				wdata = '0;
			end
			ST_IDLE: begin
				if (acc && in_data.mode == MODE_WRITE && in_ok) begin
					we    = 1'b1;
					waddr = cell_addr(in_pr, in_pc);
					wdata = CELL_BITS'(in_data.write_value);
				end
			end
			ST_FILL: we = 1'b1;
			ST_ROWS: begin
				we    = (rcnt_q != '0);
				waddr = cell_addr(rtgt, CW'(sweep_q));
			end
			ST_COLS: begin
				we    = (ccnt_q != '0);
				waddr = cell_addr(RW'(sweep_q), ctgt);
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			item_q       <= '0;
			res_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			cell_size_q  <= CELL_SIZE_RST;
			default_q    <= '0;
			corner_row_q <= '0;
			corner_col_q <= '0;
			nr_q         <= '0;
			nc_q         <= '0;
			row_org_q    <= '0;
			col_org_q    <= '0;
			rcnt_q       <= '0;
			ccnt_q       <= '0;
			rdir_q       <= 1'b0;
			cdir_q       <= 1'b0;
			sweep_q      <= '0;
			lin_q        <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			dneg_q       <= 1'b0;
			dsel_q       <= 1'b0;
			qy_q         <= '0;
			qx_q         <= '0;
			nx_q         <= '0;
			ny_q         <= '0;
			plo_x_q      <= '0;
			plo_y_q      <= '0;
			phi_x_q      <= '0;
			phi_y_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_CELL_SIZE: cell_size_q <= cfg_data;
					CFG_DEFAULT_CELL: default_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == ST_EMIT && out_free) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: lin_q <= lin_q + 1'b1;
				ST_IDLE: begin
					if (acc) begin
						item_q <= in_data;
						res_q  <= res_init;
						nx_q   <= ((34'(corner_col_q) + 34'(in_data.col)) <<< 1) + 34'sd1;
						ny_q   <= ((34'(corner_row_q) + 34'(in_data.row)) <<< 1) + 34'sd1;
						rem_q  <= '0;
						quo_q  <= abs32(in_data.pos_y);
						dneg_q <= in_data.pos_y[31];
						dsel_q <= 1'b0;
						cnt_q  <= '0;
						lin_q  <= '0;
						sweep_q <= '0;
					end
				end
				ST_READ: begin
					res_q.cell_value <= res_q.valid_res ? 16'(rdata_q) : 16'd0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31 && !dsel_q) begin
						qy_q   <= q_fin;
						rem_q  <= '0;
						quo_q  <= abs32(item_q.pos_x);
						dneg_q <= item_q.pos_x[31];
						dsel_q <= 1'b1;
					end else begin
						rem_q <= rem_n;
						quo_q <= quo_n;
						if (cnt_q == 5'd31) qx_q <= q_fin;
					end
				end
				ST_CALC: begin
					if (item_q.mode == MODE_TO_CELL) begin
						res_q.out_row   <= orow_c;
						res_q.out_col   <= ocol_c;
						res_q.valid_res <= !orow_c[31] && (orow_c[30:0] < 31'(GRID_ROWS)) &&
							!ocol_c[31] && (ocol_c[30:0] < 31'(GRID_COLS));
					end else begin
						nr_q <= sat32(36'(qy_q) - 36'(GRID_ROWS / 2));
						nc_q <= sat32(36'(qx_q) - 36'(GRID_COLS / 2));
					end
				end
				ST_DECIDE: begin
					if (!dzero) begin
						res_q.moved  <= 1'b1;
						corner_row_q <= nr_q;
						corner_col_q <= nc_q;
						lin_q        <= '0;
						sweep_q      <= '0;
						if (dbig) begin
							row_org_q <= '0;
							col_org_q <= '0;
						end else begin
							rcnt_q <= absdr[RW-1:0];
							ccnt_q <= absdc[CW-1:0];
							rdir_q <= dr[33];
							cdir_q <= dc[33];
						end
					end
				end
				ST_ROWS: begin
					if (rcnt_q != '0) begin
						sweep_q <= sweep_end_r ? '0 : sweep_q + 1'b1;
						if (sweep_end_r) begin
							rcnt_q    <= rcnt_q - 1'b1;
							row_org_q <= rdir_q ? dec_r(row_org_q) : inc_r(row_org_q);
						end
					end
				end
				ST_COLS: begin
					if (ccnt_q != '0) begin
						sweep_q <= sweep_end_c ? '0 : sweep_q + 1'b1;
						if (sweep_end_c) begin
							ccnt_q    <= ccnt_q - 1'b1;
							col_org_q <= cdir_q ? dec_c(col_org_q) : inc_c(col_org_q);
						end
					end
				end
				ST_FILL: lin_q <= lin_q + 1'b1;
				ST_MUL1: begin
					plo_x_q <= magx[31:0] * den;
					phi_x_q <= magx[33:32] * den;
					plo_y_q <= magy[31:0] * den;
					phi_y_q <= magy[33:32] * den;
				end
				ST_MUL2: begin
					res_q.out_x <= half_sat(px_sum, nx_q[33]);
					res_q.out_y <= half_sat(py_sum, ny_q[33]);
				end
				default: ;
			endcase
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scrolling grid map store testbench
// Drives reads, writes, recenters, clears and both position conversions
// through several cell size and default value settings, predicts every
// result with a local map model and checks each result item in order.
// ----------------------------------------------------------------------------
module tb_top;
	import sgms_pkg::*;

	localparam int ROWS = GRID_ROWS_DEF;
	localparam int COLS = GRID_COLS_DEF;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;

	typedef struct {
		in_item_t it;
		bit       small_move;
		int       d_r;
		int       d_c;
	} job_t;

	logic      clk;
	logic      arst_n;
	in_item_t  in_data;
	logic      in_valid;
	logic      in_stall;
	out_item_t out_data;
	logic      out_valid;
	logic      out_stall;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	scrolling_grid_map_store_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
		.out_data(out_data), .out_valid(out_valid), .out_stall(out_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Local copy of the map state.
	logic [15:0] map_cells [0:ROWS*COLS-1];
	longint      base_row, base_col;
	int          org_r, org_c;
	logic [31:0] cell_sz;
	logic [15:0] fill_val;

	job_t      pending_q[$];
	out_item_t expected_q[$];
	int        items_sent, results_seen, mismatches, moves_seen, pause_at;
	bit        in_took, calm;
	int        in_gap, out_gap, calm_cnt;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > S32_HI) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < S32_LO) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic longint cell_res();
		return (cell_sz == 32'd0) ? 64'd1 : longint'({32'd0, cell_sz});
	endfunction

	// Half of an odd count of cells times the cell size, rounded down.
	function automatic logic signed [31:0] half_cells(longint n, longint res);
		logic [127:0] p;
		longint       mag;
		longint       t;
		mag = (n < 0) ? -n : n;
		p = 128'(mag) * 128'(res);
		if (n >= 0) begin
			p = p >> 1;
			return (p > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : p[31:0];
		end
		p = (p >> 1) + (p & 128'd1);
		if (p > 128'h8000_0000) begin
			return 32'sh8000_0000;
		end
		t = p[62:0];
		return clip32(-t);
	endfunction

	function automatic bit on_grid(longint r, longint c);
		return r >= 0 && c >= 0 && r < ROWS && c < COLS;
	endfunction

	function automatic int cell_addr(longint r, longint c);
		int pr;
		int pc;
		pr = int'(r) + org_r;
		pc = int'(c) + org_c;
		if (pr >= ROWS) begin
			pr = pr - ROWS;
		end
		if (pc >= COLS) begin
			pc = pc - COLS;
		end
		return pr * COLS + pc;
	endfunction

	function automatic void fill_row(int pr);
		for (int c = 0; c < COLS; c++) begin
			map_cells[pr*COLS + c] = fill_val;
		end
	endfunction

	function automatic void fill_col(int pc);
		for (int r = 0; r < ROWS; r++) begin
			map_cells[r*COLS + pc] = fill_val;
		end
	endfunction

	function automatic void fill_map();
		for (int i = 0; i < ROWS*COLS; i++) begin
			map_cells[i] = fill_val;
		end
	endfunction

	function automatic bit shift_map(longint px, longint py);
		longint res;
		longint nr;
		longint nc;
		longint dr;
		longint dc;
		res = cell_res();
		nr = clip32(floor_quot(py, res) - ROWS/2);
		nc = clip32(floor_quot(px, res) - COLS/2);
		dr = nr - base_row;
		dc = nc - base_col;
		if (dr == 0 && dc == 0) begin
			return 1'b0;
		end
		if (dr >= ROWS || -dr >= ROWS || dc >= COLS || -dc >= COLS) begin
			fill_map();
			org_r = 0;
			org_c = 0;
		end else begin
			for (longint i = 0; i < dr; i++) begin
				fill_row(org_r);
				org_r = (org_r + 1 == ROWS) ? 0 : org_r + 1;
			end
			for (longint i = 0; i < -dr; i++) begin
				org_r = (org_r == 0) ? ROWS - 1 : org_r - 1;
				fill_row(org_r);
			end
			for (longint i = 0; i < dc; i++) begin
				fill_col(org_c);
				org_c = (org_c + 1 == COLS) ? 0 : org_c + 1;
			end
			for (longint i = 0; i < -dc; i++) begin
				org_c = (org_c == 0) ? COLS - 1 : org_c - 1;
				fill_col(org_c);
			end
		end
		base_row = nr;
		base_col = nc;
		return 1'b1;
	endfunction

	function automatic out_item_t map_response(in_item_t it);
		out_item_t o;
		longint    r;
		longint    c;
		longint    res;
		o = '0;
		r = it.row;
		c = it.col;
		res = cell_res();
		case (it.mode)
			MODE_READ: begin
				if (on_grid(r, c)) begin
					o.valid_res = 1'b1;
					o.cell_value = map_cells[cell_addr(r, c)];
				end
			end
			MODE_WRITE: begin
				if (on_grid(r, c)) begin
					o.valid_res = 1'b1;
					map_cells[cell_addr(r, c)] = it.write_value;
				end
			end
			MODE_RECENTER: begin
				o.moved = shift_map(it.pos_x, it.pos_y);
			end
			MODE_CLEAR: begin
				fill_map();
			end
			MODE_TO_CELL: begin
				o.out_row = clip32(floor_quot(it.pos_y, res) - base_row);
				o.out_col = clip32(floor_quot(it.pos_x, res) - base_col);
				o.valid_res = on_grid(o.out_row, o.out_col);
			end
			MODE_CENTER: begin
				o.out_x = half_cells(2 * (base_col + c) + 1, res);
				o.out_y = half_cells(2 * (base_row + r) + 1, res);
				o.valid_res = on_grid(r, c);
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// A recenter by a few cells is built from the corner in force when the
	// item leaves the queue, so that it scrolls instead of jumping.
	function automatic in_item_t resolve_job(job_t j);
		in_item_t it;
		longint   res;
		longint   py;
		longint   px;
		it = j.it;
		if (j.small_move) begin
			res = cell_res();
			py = (base_row + ROWS/2 + j.d_r) * res + longint'($urandom) % res;
			px = (base_col + COLS/2 + j.d_c) * res + longint'($urandom) % res;
			if (py > S32_HI || py < S32_LO || px > S32_HI || px < S32_LO) begin
				it.mode = MODE_TO_CELL;
			end else begin
				it.pos_y = py[31:0];
				it.pos_x = px[31:0];
			end
		end
		return it;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (calm || k < 55) begin
			return 0;
		end
		if (k < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_q.push_back(map_response(in_data));
				items_sent <= items_sent + 1;
			end
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) begin
						$display("unexpected result item %p", out_data);
					end
				end else begin
					if (expected_q[0].moved) begin
						moves_seen <= moves_seen + 1;
					end
					if (out_data !== expected_q[0]) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10) begin
							$display("mismatch: expected %p", expected_q[0]);
							$display("          actual   %p", out_data);
						end
					end
					void'(expected_q.pop_front());
				end
			end
		end
	end

	always @(negedge clk) begin
		calm_cnt <= calm_cnt + 1;
		if (calm_cnt % 300 == 0) begin
			calm <= ($urandom_range(0, 3) == 0);
		end
		if (!in_valid || in_took) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0
					&& !(items_sent == pause_at && expected_q.size() != 0)) begin
				in_data <= resolve_job(pending_q.pop_front());
				in_valid <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			out_gap <= pick_gap();
		end
	end

	task automatic push_item(logic [2:0] mode, int r, int c, logic [15:0] wv,
			longint px, longint py);
		job_t j;
		j.it.mode = mode;
		j.it.row = r[15:0];
		j.it.col = c[15:0];
		j.it.write_value = wv;
		j.it.pos_x = px[31:0];
		j.it.pos_y = py[31:0];
		j.small_move = 1'b0;
		j.d_r = 0;
		j.d_c = 0;
		pending_q.push_back(j);
	endtask

	task automatic push_move(int dr, int dc);
		push_item(MODE_RECENTER, 0, 0, 16'd0, 0, 0);
		pending_q[$].small_move = 1'b1;
		pending_q[$].d_r = dr;
		pending_q[$].d_c = dc;
	endtask

	task automatic set_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == CFG_CELL_SIZE) begin
			cell_sz = val;
		end else begin
			fill_val = val[15:0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	int jumps_left;
	int clears_left;

	task automatic push_random();
		int k;
		int r;
		int c;
		k = $urandom_range(0, 99);
		r = $urandom_range(0, ROWS - 1);
		c = $urandom_range(0, COLS - 1);
		if ($urandom_range(0, 6) == 0) begin
			r = $urandom_range(0, 65535);
			c = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : c;
		end
		if (k < 30) begin
			push_item(MODE_WRITE, r, c, 16'($urandom), $urandom, $urandom);
			if ($urandom_range(0, 1) != 0) begin
				push_item(MODE_READ, r, c, 16'($urandom), $urandom, $urandom);
			end
		end else if (k < 55) begin
			push_item(MODE_READ, r, c, 16'($urandom), $urandom, $urandom);
		end else if (k < 70) begin
			push_move($urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2);
			push_item(MODE_READ, $urandom_range(0, 3) == 0 ? 0 : r, c, 0, 0, 0);
		end else if (k < 82) begin
			push_item(MODE_TO_CELL, r, c, 16'($urandom), $urandom, $urandom);
		end else if (k < 94) begin
			push_item(MODE_CENTER, r, c, 16'($urandom), $urandom, $urandom);
		end else if (k < 97) begin
			push_item($urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI,
				r, c, 16'($urandom), $urandom, $urandom);
		end else if (k < 98 && jumps_left > 0) begin
			jumps_left--;
			push_item(MODE_RECENTER, r, c, 16'($urandom), $urandom, $urandom);
		end else if (k < 99 && clears_left > 0) begin
			clears_left--;
			push_item(MODE_CLEAR, r, c, 16'($urandom), $urandom, $urandom);
		end else begin
			push_item(MODE_READ, r, c, 16'($urandom), $urandom, $urandom);
		end
	endtask

	initial begin
		logic [31:0] sizes [5];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_sent = 0;
		results_seen = 0;
		mismatches = 0;
		moves_seen = 0;
		in_gap = 0;
		out_gap = 0;
		calm = 1'b0;
		calm_cnt = 1;
		pause_at = 300;
		jumps_left = 2;
		clears_left = 1;
		base_row = 0;
		base_col = 0;
		org_r = 0;
		org_c = 0;
		cell_sz = CELL_SIZE_RST;
		fill_val = '0;
		for (int i = 0; i < ROWS*COLS; i++) begin
			map_cells[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_reg(CFG_CELL_SIZE, CELL_SIZE_RST);
		set_reg(CFG_DEFAULT_CELL, 32'h0000_BEEF);
		push_item(MODE_READ, 9, 9, 16'h0, 0, 0);
		push_item(MODE_WRITE, 0, 0, 16'hFFFF, 0, 0);
		push_item(MODE_READ, 0, 0, 16'h0, 0, 0);
		push_item(MODE_WRITE, 255, 255, 16'h0000, 0, 0);
		push_item(MODE_READ, 255, 255, 16'hFFFF, 0, 0);
		push_item(MODE_WRITE, -1, 0, 16'h1234, 0, 0);
		push_item(MODE_READ, 256, 5, 16'h0, 0, 0);
		push_item(MODE_READ, -32768, 32767, 16'h0, 0, 0);
		push_item(MODE_WRITE, 32767, -32768, 16'h5555, 0, 0);
		push_item(MODE_TO_CELL, 0, 0, 0, S32_LO, S32_HI);
		push_item(MODE_TO_CELL, 0, 0, 0, S32_HI, S32_LO);
		push_item(MODE_TO_CELL, 0, 0, 0, 0, 0);
		push_item(MODE_CENTER, 0, 0, 0, 0, 0);
		push_item(MODE_CENTER, 255, 255, 0, 0, 0);
		push_item(MODE_CENTER, -32768, -32768, 0, 0, 0);
		push_item(MODE_CENTER, 32767, 32767, 0, 0, 0);
		push_move(1, -1);
		push_item(MODE_READ, 255, 0, 16'h0, 0, 0);
		push_move(0, 0);
		push_item(MODE_RECENTER, 0, 0, 0, S32_HI, S32_LO);
		push_item(MODE_READ, 3, 3, 16'h0, 0, 0);
		push_item(MODE_CLEAR, 0, 0, 0, 0, 0);
		push_item(MODE_READ, 7, 7, 16'h0, 0, 0);
		push_item(MODE_SPARE_LO, 1, 1, 16'hFFFF, S32_LO, S32_LO);
		push_item(MODE_SPARE_HI, 1, 1, 16'hFFFF, S32_HI, S32_HI);
		drain();

		sizes = '{32'd65536, 32'd1, 32'd0, 32'hFFFF_FFFF, CELL_SIZE_RST};
		foreach (sizes[p]) begin
			set_reg(CFG_CELL_SIZE, sizes[p]);
			set_reg(CFG_DEFAULT_CELL, (p == 0) ? 32'h0000_FFFF : $urandom);
			for (int n = 0; n < 140; n++) begin
				push_random();
			end
			drain();
		end

		$display("covered %0d items and %0d results, %0d of them moved the map,",
			items_sent, results_seen, moves_seen);
		$display("across five cell sizes from zero to full scale; %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timed out with %0d results outstanding", expected_q.size());
		$display("status: fail");
		$finish;
	end

endmodule
